/* rtl/core/sbsm_pkg.sv */
// Package for the serial bank switch mapper: field widths, register indexes,
// target codes and the bank select helper. No dependencies.
`timescale 1ns / 1ps

package sbsm_pkg;

    localparam int BANK_W   = 7;
    localparam int SEL_W    = 5;
    localparam int CNT_W    = 3;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int MIRROR_W = 2;
    localparam int CFG_IDX_W = 2;

    // Packed widths of the stream payloads, rounded up to whole bytes.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // Serial load completes on this bit.
    localparam logic [CNT_W-1:0] LOAD_BITS = 3'd5;

    // Reset values of the state.
    localparam logic [SEL_W-1:0]  CONTROL_RESET  = 5'h0C;
    localparam logic [SEL_W-1:0]  PRG_MODE_BITS  = 5'h0C;
    localparam logic [BANK_W-1:0] BANK_COUNT_RESET = 7'd16;
    localparam logic [BANK_W-1:0] PRG_HIGH_RESET = 7'd15;
    localparam logic [BANK_W-1:0] CHR_HIGH_RESET = 7'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_BANK_COUNT = 2'd1;

    // Targets chosen by address bits 14:13.
    typedef enum logic [1:0] {
        TGT_CONTROL  = 2'd0,
        TGT_CHR_LOW  = 2'd1,
        TGT_CHR_HIGH = 2'd2,
        TGT_PRG      = 2'd3
    } target_t;

    // Mirroring codes.
    localparam logic [MIRROR_W-1:0] MIR_SINGLE     = 2'd0;
    localparam logic [MIRROR_W-1:0] MIR_VERTICAL   = 2'd1;
    localparam logic [MIRROR_W-1:0] MIR_HORIZONTAL = 2'd2;

    // Control register bit positions.
    localparam int CTL_HORIZ   = 0;
    localparam int CTL_MULTI   = 1;
    localparam int CTL_PRG_LOW = 2;
    localparam int CTL_PRG_16K = 3;
    localparam int CTL_CHR_4K  = 4;

    // Low four select bits, plus the offset when select bit 4 is set, wrapped to 7 bits.
    function automatic logic [BANK_W-1:0] select_value(input logic [SEL_W-1:0] sel,
                                                       input logic [BANK_W-1:0] extra);
        logic [BANK_W-1:0] base;
        base = {{(BANK_W-4){1'b0}}, sel[3:0]};
        return sel[4] ? base + extra : base;
    endfunction

endpackage

/* rtl/core/serial_bank_switch_mapper.sv */
// Serial bank switch mapper top level: serial shifter, bank registers and
// result register. Depends on sbsm_pkg.
// Each result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle; a new write is taken whenever the result
// register is empty or its beat is taken in the same cycle.
// Reset (aresetn low, synchronous) restores the power-up bank state, both
// bank counts to 16 and clears the result valid.
`timescale 1ns / 1ps

module serial_bank_switch_mapper (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port.
    input  logic                           cfg_wen,
    input  logic [sbsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbsm_pkg::BANK_W-1:0]    cfg_data,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sbsm_pkg::S_TDATA_W-1:0] s_tdata,   // addr[15:0], data[23:16]
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // mirroring[1:0], prg_bank_low[8:2], prg_bank_high[15:9],
    // chr_bank_low[22:16], chr_bank_high[29:23], zero[31:30]
    output logic [sbsm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser    // committed
);

    // Configuration registers.
    logic [sbsm_pkg::BANK_W-1:0] prg_count_reg;
    logic [sbsm_pkg::BANK_W-1:0] chr_count_reg;

    // Mapper state.
    logic [sbsm_pkg::SEL_W-1:0]    shift_reg, shift_next;
    logic [sbsm_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [sbsm_pkg::SEL_W-1:0]    control_reg, control_next;
    logic [sbsm_pkg::SEL_W-1:0]    chr_sel_low_reg, chr_sel_low_next;
    logic [sbsm_pkg::SEL_W-1:0]    chr_sel_high_reg, chr_sel_high_next;
    logic [sbsm_pkg::MIRROR_W-1:0] mirror_reg, mirror_next;
    logic [sbsm_pkg::BANK_W-1:0]   prg_low_reg, prg_low_next;
    logic [sbsm_pkg::BANK_W-1:0]   prg_high_reg, prg_high_next;
    logic [sbsm_pkg::BANK_W-1:0]   chr_low_reg, chr_low_next;
    logic [sbsm_pkg::BANK_W-1:0]   chr_high_reg, chr_high_next;
    logic                          done_next;

    // Result register.
    logic                          m_valid_reg;
    logic [sbsm_pkg::M_TDATA_W-1:0] m_data_reg;
    logic                          m_user_reg;

    // Input beat fields.
    logic [sbsm_pkg::ADDR_W-1:0] in_addr;
    logic [sbsm_pkg::DATA_W-1:0] in_data;
    logic                        in_accept;
    sbsm_pkg::target_t           target;
    logic [sbsm_pkg::SEL_W-1:0]  load_value;
    logic [sbsm_pkg::BANK_W-1:0] chr_pick;
    logic [sbsm_pkg::BANK_W-1:0] prg_pick;
    logic [sbsm_pkg::BANK_W-1:0] chr_even;
    logic [sbsm_pkg::BANK_W-1:0] prg_even;

    assign in_addr   = s_tdata[sbsm_pkg::ADDR_W-1:0];
    assign in_data   = s_tdata[sbsm_pkg::ADDR_W +: sbsm_pkg::DATA_W];
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign target    = sbsm_pkg::target_t'(in_addr[14:13]);

    // The five-bit value that completes on this beat, newest bit on top.
    assign load_value = shift_reg | ({{(sbsm_pkg::SEL_W-1){1'b0}}, in_data[0]} << count_reg);

    assign chr_pick = sbsm_pkg::select_value(load_value, chr_count_reg);
    assign prg_pick = sbsm_pkg::select_value(load_value,
                                             {1'b0, prg_count_reg[sbsm_pkg::BANK_W-1:1]});
    assign chr_even = {chr_pick[sbsm_pkg::BANK_W-1:1], 1'b0};
    assign prg_even = {prg_pick[sbsm_pkg::BANK_W-1:1], 1'b0};

    // Next state for one write beat.
    always_comb begin
        shift_next        = shift_reg;
        count_next        = count_reg;
        control_next      = control_reg;
        chr_sel_low_next  = chr_sel_low_reg;
        chr_sel_high_next = chr_sel_high_reg;
        mirror_next       = mirror_reg;
        prg_low_next      = prg_low_reg;
        prg_high_next     = prg_high_reg;
        chr_low_next      = chr_low_reg;
        chr_high_next     = chr_high_reg;
        done_next         = 1'b0;

        if (in_data[7]) begin
            // Reset write: clear the shifter and force 16K PRG mode, low bank switchable.
            shift_next   = '0;
            count_next   = '0;
            control_next = control_reg | sbsm_pkg::PRG_MODE_BITS;
        end else if (count_reg + 3'd1 == sbsm_pkg::LOAD_BITS) begin
            shift_next = '0;
            count_next = '0;
            done_next  = 1'b1;
            unique case (target)
                sbsm_pkg::TGT_CONTROL: begin
                    control_next = load_value;
                    if (!load_value[sbsm_pkg::CTL_MULTI]) begin
                        mirror_next = sbsm_pkg::MIR_SINGLE;
                    end else if (load_value[sbsm_pkg::CTL_HORIZ]) begin
                        mirror_next = sbsm_pkg::MIR_HORIZONTAL;
                    end else begin
                        mirror_next = sbsm_pkg::MIR_VERTICAL;
                    end
                end
                sbsm_pkg::TGT_CHR_LOW: begin
                    chr_sel_low_next = load_value;
                    if (control_reg[sbsm_pkg::CTL_CHR_4K]) begin
                        chr_low_next = chr_pick;
                    end else begin
                        // 8K mode: even bank low, next bank high.
                        chr_low_next  = chr_even;
                        chr_high_next = chr_even + 7'd1;
                    end
                end
                sbsm_pkg::TGT_CHR_HIGH: begin
                    chr_sel_high_next = load_value;
                    if (control_reg[sbsm_pkg::CTL_CHR_4K]) begin
                        chr_high_next = chr_pick;
                    end
                end
                sbsm_pkg::TGT_PRG: begin
                    if (control_reg[sbsm_pkg::CTL_PRG_16K]) begin
                        if (control_reg[sbsm_pkg::CTL_PRG_LOW]) begin
                            prg_low_next = prg_pick;
                        end else begin
                            prg_high_next = prg_pick;
                        end
                    end else begin
                        // 32K mode: even bank low, next bank high.
                        prg_low_next  = prg_even;
                        prg_high_next = prg_even + 7'd1;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            shift_next = load_value;
            count_next = count_reg + 3'd1;
        end
    end

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_count_reg <= sbsm_pkg::BANK_COUNT_RESET;
            chr_count_reg <= sbsm_pkg::BANK_COUNT_RESET;
        end else if (cfg_wen) begin
            if (cfg_index == sbsm_pkg::CFG_PRG_BANK_COUNT) begin
                prg_count_reg <= cfg_data;
            end else if (cfg_index == sbsm_pkg::CFG_CHR_BANK_COUNT) begin
                chr_count_reg <= cfg_data;
            end
        end
    end

    // Mapper state update on each accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg        <= '0;
            count_reg        <= '0;
            control_reg      <= sbsm_pkg::CONTROL_RESET;
            chr_sel_low_reg  <= '0;
            chr_sel_high_reg <= '0;
            mirror_reg       <= sbsm_pkg::MIR_SINGLE;
            prg_low_reg      <= '0;
            prg_high_reg     <= sbsm_pkg::PRG_HIGH_RESET;
            chr_low_reg      <= '0;
            chr_high_reg     <= sbsm_pkg::CHR_HIGH_RESET;
        end else if (in_accept) begin
            shift_reg        <= shift_next;
            count_reg        <= count_next;
            control_reg      <= control_next;
            chr_sel_low_reg  <= chr_sel_low_next;
            chr_sel_high_reg <= chr_sel_high_next;
            mirror_reg       <= mirror_next;
            prg_low_reg      <= prg_low_next;
            prg_high_reg     <= prg_high_next;
            chr_low_reg      <= chr_low_next;
            chr_high_reg     <= chr_high_next;
        end
    end

    // Result register: valid control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result register: payload, loaded with the state after this beat.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_data_reg <= {2'b00, chr_high_next, chr_low_next, prg_high_next,
                           prg_low_next, mirror_next};
            m_user_reg <= done_next;
        end
    end

    // Result stream outputs straight from the result register.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
